[sv/bif_pkg.sv]
package bif_pkg;

    // frame geometry limits
    localparam logic [10:0] MAX_WIDTH   = 11'd1024;
    localparam logic [12:0] MAX_HEIGHT  = 13'd4096;
    localparam logic [1:0]  MAX_RADIUS  = 2'd3;
    localparam int          COL_W       = 10;
    localparam int          LINE_W      = 3;
    localparam int          STORE_DEPTH = 8 * 1024;
    localparam int          ADDR_W      = LINE_W + COL_W;

    // configuration register indexes
    localparam int          CFG_IDX_W        = 2;
    localparam logic [1:0]  REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0]  REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0]  REG_RADIUS       = 2'd2;

    // input item kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // weight table construction
    localparam int SIGMA_SPATIAL = 3;
    localparam int SIGMA_RANGE   = 30;
    localparam int SP_SIZE       = 2 * 3 * 3 + 1;
    localparam longint unsigned SP_DEN    = 2 * SIGMA_SPATIAL * SIGMA_SPATIAL;
    localparam longint unsigned RG_DEN    = 2 * SIGMA_RANGE * SIGMA_RANGE;
    localparam logic [63:0]     Q32_ONE   = 64'h1_0000_0000;
    localparam logic [63:0]     INV_E_Q32 = 64'h5E2D_58D9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_POS,
        ST_DIV,
        ST_WRITE,
        ST_CENTRE,
        ST_TAPS,
        ST_DRAIN,
        ST_NORM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       clear;
        logic       acc;
        logic       step;
        logic [2:0] bit_sel;
    } lane_ctl_t;

    typedef logic [15:0] sp_rom_t [SP_SIZE];
    typedef logic [15:0] rg_rom_t [256];

    // 65536*exp(-(k + f/2^32)), Q16, k integer part, f Q32 fraction
    function automatic logic [15:0] exp_q16(input logic [63:0] k, input logic [63:0] f);
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] g;
        logic [63:0] v;
        logic [63:0] r;
        t = Q32_ONE;
        s = Q32_ONE;
        g = Q32_ONE;
        t = ((t * f) >> 32) / 1;  s = s - t;
        t = ((t * f) >> 32) / 2;  s = s + t;
        t = ((t * f) >> 32) / 3;  s = s - t;
        t = ((t * f) >> 32) / 4;  s = s + t;
        t = ((t * f) >> 32) / 5;  s = s - t;
        t = ((t * f) >> 32) / 6;  s = s + t;
        t = ((t * f) >> 32) / 7;  s = s - t;
        t = ((t * f) >> 32) / 8;  s = s + t;
        t = ((t * f) >> 32) / 9;  s = s - t;
        t = ((t * f) >> 32) / 10; s = s + t;
        t = ((t * f) >> 32) / 11; s = s - t;
        t = ((t * f) >> 32) / 12; s = s + t;
        t = ((t * f) >> 32) / 13; s = s - t;
        t = ((t * f) >> 32) / 14; s = s + t;
        t = ((t * f) >> 32) / 15; s = s - t;
        t = ((t * f) >> 32) / 16; s = s + t;
        for (int n = 0; n < 64; n++) begin
            if (64'(n) < k && g != 64'd0) begin
                g = (g * INV_E_Q32) >> 32;
            end
        end
        v = (g == Q32_ONE) ? s : ((g * s) >> 32);
        r = (v + 64'd32768) >> 16;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic sp_rom_t build_sp();
        sp_rom_t     rom;
        logic [63:0] a;
        for (int i = 0; i < SP_SIZE; i++) begin
            a = 64'(i);
            rom[i] = exp_q16(a / SP_DEN, ((a % SP_DEN) << 32) / SP_DEN);
        end
        return rom;
    endfunction

    function automatic rg_rom_t build_rg();
        rg_rom_t     rom;
        logic [63:0] a;
        for (int i = 0; i < 256; i++) begin
            a = 64'(i * i);
            rom[i] = exp_q16(a / RG_DEN, ((a % RG_DEN) << 32) / RG_DEN);
        end
        return rom;
    endfunction

    localparam sp_rom_t SP_ROM = build_sp();
    localparam rg_rom_t RG_ROM = build_rg();

endpackage

[sv/bif_rowdiv.sv]
module bif_rowdiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [22:0] dividend,
    input  logic [10:0] divisor,
    output logic        busy,
    output logic [12:0] quotient,
    output logic [10:0] remainder
);
    import bif_pkg::*;

    logic [22:0] rem_reg;
    logic [12:0] quo_reg;
    logic [10:0] dvs_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic [23:0] dsh;

    // divisor aligned to the current quotient bit
    assign dsh = {13'b0, dvs_reg} << cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'd12;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 4'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dvs_reg <= divisor;
            quo_reg <= 13'd0;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= dsh)
            begin
                rem_reg          <= rem_reg - dsh[22:0];
                quo_reg[cnt_reg] <= 1'b1;
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[10:0];

endmodule

[sv/bif_lane.sv]
module bif_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  bif_pkg::lane_ctl_t ctl,
    input  logic [15:0]        sw,
    input  logic [7:0]         a,
    input  logic [7:0]         b,
    output logic [7:0]         result
);
    import bif_pkg::*;

    logic        v1_reg;
    logic        v2_reg;
    logic [15:0] rg1_reg;
    logic [15:0] sw1_reg;
    logic [7:0]  a1_reg;
    logic [7:0]  a2_reg;
    logic [31:0] w2_reg;
    logic [45:0] num_reg;
    logic [37:0] den_reg;
    logic [7:0]  quo_reg;
    logic [7:0]  diff;
    logic [45:0] dsh;

    assign diff = (a > b) ? (a - b) : (b - a);
    assign dsh  = {8'b0, den_reg} << ctl.bit_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.acc;
            v2_reg <= v1_reg;
        end
    end

    // lookup, weight product, accumulate, normalizing division step
    always_ff @(posedge clk)
    begin
        rg1_reg <= RG_ROM[diff];
        sw1_reg <= sw;
        a1_reg  <= a;
        w2_reg  <= {16'b0, sw1_reg} * {16'b0, rg1_reg};
        a2_reg  <= a1_reg;
        if (ctl.clear)
        begin
            num_reg <= 46'd0;
            den_reg <= 38'd0;
            quo_reg <= 8'd0;
        end
        else if (v2_reg)
        begin
            num_reg <= num_reg + 46'({8'b0, w2_reg} * {32'b0, a2_reg});
            den_reg <= den_reg + 38'(w2_reg);
        end
        else if (ctl.step)
        begin
            // quotient never exceeds 255: weighted mean of 8-bit values
            if (num_reg >= dsh)
            begin
                num_reg              <= num_reg - dsh;
                quo_reg[ctl.bit_sel] <= 1'b1;
            end
        end
    end

    assign result = (den_reg == 38'd0) ? b : quo_reg;

endmodule

[sv/bilateral_image_filter.sv]
// Streaming bilateral filter for RGBA pixels in raster order. Every input transaction on
// the slave side (tuser = 0 pixel, 1 flush) advances the raster position by one; a flush
// past the frame end lets the last rows drain. Once the window of the pixel lagging
// radius*width + min(radius, width-1) positions behind is complete, that pixel leaves on
// the master side: R, G, B replaced by sum(p*w)/sum(w) over in-frame neighbours within
// the radius (w = spatial Gaussian times range Gaussian, Q0.16 tables), alpha unchanged,
// with its row, column and a tlast on the final pixel of the frame. Each transaction
// runs a 13-step position divider and, inside the frame, writes the line store; when a
// pixel is emitted, it then walks the window through the single read port of the line
// store, one window tap per cycle, runs an 8-step normalizing divider in each channel
// lane and, if needed, waits for a free output register. A finished pixel waits in the
// output register while the next transaction is accepted. Configuration is written
// through cfg_we/cfg_index/cfg_data while the block is idle (the user keeps to this;
// the block does not enforce it); the line store is not cleared after reset.
module bilateral_image_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [bif_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
    input  logic [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_red, out_green, out_blue, out_alpha,
                                        // out_row[11:0], out_column[9:0], zero pad
    output logic        m_axis_tlast    // last_pixel
);
    import bif_pkg::*;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [1:0]  radius_reg;
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic [1:0]  r_eff;
    logic [10:0] wm1;
    logic [1:0]  m_eff;

    // per transaction
    logic [31:0] pix_reg;
    logic [22:0] total_reg;
    logic [11:0] lag_reg;
    logic [1:0]  m_reg;
    logic [22:0] raster_position_reg;
    logic        last_reg;
    logic        emit_reg;
    logic        wr_reg;
    logic [12:0] r0_reg;
    logic [9:0]  c0_reg;
    logic [22:0] end_pos;
    logic [22:0] p_pos;

    // window walk
    logic signed [2:0] dr_reg;
    logic signed [2:0] dc_reg;
    logic signed [2:0] r_signed;
    logic [2:0]        step_reg;
    logic              tap_vld_d_reg;
    logic              centre_d_reg;
    logic [4:0]        sp_idx_d_reg;
    logic [31:0]       centre_reg;
    logic signed [14:0] rr;
    logic signed [11:0] cc;
    logic              in_frame;
    logic              last_tap;
    logic [1:0]        adr;
    logic [1:0]        adc;
    logic [4:0]        sp_idx;

    // line store
    logic [31:0]       store_mem [STORE_DEPTH];
    logic [31:0]       rdata_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // position divider
    logic        div_start;
    logic        div_busy;
    logic [12:0] prow;
    logic [10:0] pcol;

    // lanes and output
    lane_ctl_t   lane_ctl;
    logic [7:0]  lane_res [3];
    logic        out_free;
    logic        out_load;
    logic        m_valid_reg;
    logic [55:0] m_data_reg;
    logic        m_last_reg;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 13'd1024;
            radius_reg <= 2'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[10:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                REG_RADIUS:       radius_reg <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // out-of-range settings fold to the nearest legal value
    assign w_eff = (width_reg == 11'd0) ? 11'd1 :
                   (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    assign h_eff = (height_reg == 13'd0) ? 13'd1 :
                   (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    assign r_eff = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
    assign wm1   = w_eff - 11'd1;
    assign m_eff = (wm1 > {9'b0, r_eff}) ? r_eff : wm1[1:0];
    assign r_signed = $signed({1'b0, r_eff});

    // ---------------- position bookkeeping ----------------
    assign end_pos = total_reg + {11'b0, lag_reg} - 23'd1;
    assign p_pos   = (raster_position_reg > end_pos) ? 23'd0 : raster_position_reg;
    assign div_start = (state_reg == ST_POS);

    bif_rowdiv u_rowdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (p_pos),
        .divisor   (w_eff),
        .busy      (div_busy),
        .quotient  (prow),
        .remainder (pcol)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raster_position_reg <= 23'd0;
        end
        else if (state_reg == ST_POS)
        begin
            raster_position_reg <= (p_pos == end_pos) ? 23'd0 : p_pos + 23'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            pix_reg <= (s_axis_tuser[0] == ACT_FLUSH) ? 32'd0 : s_axis_tdata;
        end
        if (state_reg == ST_PREP)
        begin
            total_reg <= 23'({12'b0, w_eff} * {10'b0, h_eff});
            lag_reg   <= 12'({10'b0, r_eff} * {1'b0, w_eff}) + {10'b0, m_eff};
            m_reg     <= m_eff;
        end
        if (state_reg == ST_POS)
        begin
            last_reg <= (p_pos == end_pos);
            emit_reg <= (p_pos >= {11'b0, lag_reg});
            wr_reg   <= (p_pos < total_reg);
        end
        if (state_reg == ST_WRITE)
        begin
            // centre = current position minus the lag, in row/column form
            if (pcol >= {9'b0, m_reg})
            begin
                c0_reg <= 10'(pcol - {9'b0, m_reg});
                r0_reg <= prow - {11'b0, r_eff};
            end
            else
            begin
                c0_reg <= 10'(pcol + w_eff - {9'b0, m_reg});
                r0_reg <= prow - {11'b0, r_eff} - 13'd1;
            end
            dr_reg <= 3'sd0 - r_signed;
            dc_reg <= 3'sd0 - r_signed;
        end
        else if (state_reg == ST_TAPS)
        begin
            if (dc_reg == r_signed)
            begin
                dc_reg <= 3'sd0 - r_signed;
                dr_reg <= dr_reg + 3'sd1;
            end
            else
            begin
                dc_reg <= dc_reg + 3'sd1;
            end
        end
    end

    // ---------------- window walk ----------------
    assign rr = $signed({2'b0, r0_reg}) + $signed({{12{dr_reg[2]}}, dr_reg});
    assign cc = $signed({2'b0, c0_reg}) + $signed({{9{dc_reg[2]}}, dc_reg});
    assign in_frame = (rr >= 15'sd0) && (rr < $signed({2'b0, h_eff})) &&
                      (cc >= 12'sd0) && (cc < $signed({1'b0, w_eff}));
    assign last_tap = (dr_reg == r_signed) && (dc_reg == r_signed);
    assign adr      = dr_reg[2] ? 2'(-dr_reg) : dr_reg[1:0];
    assign adc      = dc_reg[2] ? 2'(-dc_reg) : dc_reg[1:0];
    assign sp_idx   = 5'({2'b0, adr} * {2'b0, adr}) + 5'({2'b0, adc} * {2'b0, adc});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_vld_d_reg <= 1'b0;
            centre_d_reg  <= 1'b0;
        end
        else
        begin
            tap_vld_d_reg <= (state_reg == ST_TAPS) && in_frame;
            centre_d_reg  <= (state_reg == ST_CENTRE);
        end
    end

    always_ff @(posedge clk)
    begin
        sp_idx_d_reg <= sp_idx;
        if (centre_d_reg)
        begin
            centre_reg <= rdata_reg;
        end
        if (state_reg == ST_TAPS)
        begin
            step_reg <= 3'd0;
        end
        else if (state_reg == ST_DRAIN)
        begin
            step_reg <= (step_reg == 3'd2) ? 3'd7 : step_reg + 3'd1;
        end
        else if (state_reg == ST_NORM)
        begin
            step_reg <= step_reg - 3'd1;
        end
    end

    // ---------------- line store ----------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE && wr_reg)
        begin
            store_mem[{prow[LINE_W-1:0], pcol[COL_W-1:0]}] <= pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    // ---------------- channel lanes ----------------
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        bif_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (lane_ctl),
            .sw     (SP_ROM[sp_idx_d_reg]),
            .a      (rdata_reg[8*ch +: 8]),
            .b      (centre_reg[8*ch +: 8]),
            .result (lane_res[ch])
        );
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_axis_tvalid) state_next = ST_PREP;
            ST_PREP:   state_next = ST_POS;
            ST_POS:    state_next = ST_DIV;
            ST_DIV:    if (!div_busy) state_next = ST_WRITE;
            ST_WRITE:  state_next = emit_reg ? ST_CENTRE : ST_IDLE;
            ST_CENTRE: state_next = ST_TAPS;
            ST_TAPS:   if (last_tap) state_next = ST_DRAIN;
            ST_DRAIN:  if (step_reg == 3'd2) state_next = ST_NORM;
            ST_NORM:   if (step_reg == 3'd0) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready    = (state_reg == ST_IDLE);
        rd_en            = 1'b0;
        rd_addr          = {c0_reg[LINE_W-1:0], c0_reg};
        lane_ctl.clear   = (state_reg == ST_WRITE);
        lane_ctl.acc     = tap_vld_d_reg;
        lane_ctl.step    = (state_reg == ST_NORM);
        lane_ctl.bit_sel = step_reg;
        out_load         = 1'b0;
        unique case (state_reg)
            ST_CENTRE:
            begin
                rd_en   = 1'b1;
                rd_addr = {r0_reg[LINE_W-1:0], c0_reg};
            end
            ST_TAPS:
            begin
                rd_en   = 1'b1;
                rd_addr = {rr[LINE_W-1:0], cc[COL_W-1:0]};
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- output register ----------------
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= {2'b0, c0_reg, r0_reg[11:0], centre_reg[31:24],
                           lane_res[2], lane_res[1], lane_res[0]};
            m_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    // one transaction at a time: no accept directly after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // store write uses the divider result, so it must be settled
    a_div_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> !div_busy)
        else $error("position divider still busy at store write");

    // lane pipelines are empty once normalization starts
    a_lanes_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM) |-> (!tap_vld_d_reg && !centre_d_reg))
        else $error("tap still in flight during normalization");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_valid_reg || m_axis_tready))
        else $error("output register overwritten");
`endif

endmodule

[tb/bilateral_image_filter_tb.sv]
// Self-checking bench for the streaming bilateral filter.
// An initial block builds frames of pixel/flush transactions and runs
// every one of them through a local predictor, so the queue of expected filtered
// pixels is filled as the stimulus is built. A clocked driver feeds the slave
// side from the pending queue. A clocked monitor checks each master-side
// transaction against the oldest expected pixel.
module bilateral_image_filter_tb;
    import bif_pkg::*;

    localparam int LINE_CNT = 8;   // rows kept in the line store
    localparam int ROW_PITCH = 1024;

    typedef struct packed {
        logic        act;
        logic [31:0] pix;          // {alpha, blue, green, red}
    } pix_item_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } filt_pix_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [12:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    bilateral_image_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    pix_item_t   pending_q[$];
    filt_pix_t   filtered_q[$];
    int          errors;
    bit          no_gaps;      // burst stretches without idling

    // predictor state
    logic [15:0]  spatial_w[19];
    logic [15:0]  range_w[256];
    logic [31:0]  img_lines[LINE_CNT*ROW_PITCH];
    int unsigned  pos;
    logic [10:0]  width_reg;
    logic [12:0]  height_reg;
    logic [1:0]   radius_reg;

    // 65536*exp(-a/b) in Q16: Taylor series for the fraction, repeated 1/e for
    // the integer part, rounded half up and saturated
    function automatic logic [15:0] gauss_q16(input longint unsigned a,
                                              input longint unsigned b);
        longint unsigned whole, frac, term, acc, scale, v, r;
        whole = a / b;
        frac  = ((a % b) << 32) / b;
        term  = 64'h1_0000_0000;
        acc   = term;
        scale = term;
        for (int n = 1; n <= 16; n++)
        begin
            term = ((term * frac) >> 32) / n;
            if (n % 2 == 1) acc = acc - term;
            else            acc = acc + term;
        end
        for (longint unsigned n = 0; n < whole && scale != 0; n++)
            scale = (scale * 64'h5E2D_58D9) >> 32;
        v = (scale == 64'h1_0000_0000) ? acc : ((scale * acc) >> 32);
        r = (v + 32768) >> 16;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    // effective geometry after clamping
    function automatic int unsigned eff_w();
        return (width_reg == 0) ? 1 : (width_reg > 1024) ? 1024 : width_reg;
    endfunction
    function automatic int unsigned eff_h();
        return (height_reg == 0) ? 1 : (height_reg > 4096) ? 4096 : height_reg;
    endfunction
    function automatic int unsigned lag_of();
        int unsigned w, r;
        w = eff_w();
        r = radius_reg;
        return r * w + ((r < w - 1) ? r : w - 1);
    endfunction

    // advance the raster by one transaction; returns 1 when a pixel is emitted
    function automatic bit filter_step(input pix_item_t it, output filt_pix_t res);
        int unsigned w, h, rad, total, lag, last_pos, p, q, nb, ctr;
        int          r0, c0, rr, cc;
        longint unsigned num[3], den[3], wt, a, b;
        w = eff_w();
        h = eff_h();
        rad = radius_reg;
        total = w * h;
        lag = lag_of();
        last_pos = total - 1 + lag;
        p = (pos > last_pos) ? 0 : pos;
        if (p < total)
            img_lines[((p / w) % LINE_CNT) * ROW_PITCH + p % w] =
                (it.act == ACT_FLUSH) ? 32'd0 : it.pix;
        pos = (p == last_pos) ? 0 : p + 1;
        res = '0;
        if (p < lag) return 0;
        q = p - lag;
        r0 = q / w;
        c0 = q % w;
        ctr = img_lines[(r0 % LINE_CNT) * ROW_PITCH + c0];
        for (int k = 0; k < 3; k++)
        begin
            num[k] = 0;
            den[k] = 0;
        end
        for (int dr = -int'(rad); dr <= int'(rad); dr++)
        begin
            rr = r0 + dr;
            if (rr < 0 || rr >= int'(h)) continue;
            for (int dc = -int'(rad); dc <= int'(rad); dc++)
            begin
                cc = c0 + dc;
                if (cc < 0 || cc >= int'(w)) continue;
                nb = img_lines[(rr % LINE_CNT) * ROW_PITCH + cc];
                for (int k = 0; k < 3; k++)
                begin
                    a = (nb >> (8 * k)) & 8'hFF;
                    b = (ctr >> (8 * k)) & 8'hFF;
                    wt = longint'(spatial_w[dr * dr + dc * dc]) *
                         range_w[(a > b) ? a - b : b - a];
                    num[k] += wt * a;
                    den[k] += wt;
                end
            end
        end
        res.red   = den[0] ? 8'(num[0] / den[0]) : ctr[7:0];
        res.green = den[1] ? 8'(num[1] / den[1]) : ctr[15:8];
        res.blue  = den[2] ? 8'(num[2] / den[2]) : ctr[23:16];
        res.alpha = ctr[31:24];
        res.row   = 12'(r0);
        res.col   = 10'(c0);
        res.last  = (q == total - 1);
        return 1;
    endfunction

    function automatic void queue_item(input logic act, input logic [31:0] pix);
        pix_item_t it;
        filt_pix_t exp_pix;
        it.act = act;
        it.pix = pix;
        pending_q.push_back(it);
        if (filter_step(it, exp_pix)) filtered_q.push_back(exp_pix);
    endfunction

    // ---------------- clock, reset ----------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------- slave-side driver ----------------
    bit accepted;   // a transaction completed at the last rising edge
    int gap_left;

    always @(posedge clk)
        accepted <= s_axis_tvalid && s_axis_tready;

    function automatic int pick_gap();
        if (no_gaps) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || accepted))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                pix_item_t it;
                it = pending_q.pop_front();
                s_axis_tdata  <= it.pix;
                s_axis_tuser  <= it.act;
                s_axis_tvalid <= 1'b1;
                gap_left <= pick_gap();
                if ($urandom_range(0, 99) == 0) no_gaps <= !no_gaps;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ---------------- master-side stall and monitor ----------------
    int stall_left;

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (filtered_q.size() == 0)
            begin
                $error("unexpected output transaction %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                filt_pix_t e;
                e = filtered_q.pop_front();
                if (m_axis_tdata[7:0] !== e.red)
                begin
                    $error("out_red: expected %0d, got %0d", e.red, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[15:8] !== e.green)
                begin
                    $error("out_green: expected %0d, got %0d", e.green, m_axis_tdata[15:8]);
                    errors++;
                end
                if (m_axis_tdata[23:16] !== e.blue)
                begin
                    $error("out_blue: expected %0d, got %0d", e.blue, m_axis_tdata[23:16]);
                    errors++;
                end
                if (m_axis_tdata[31:24] !== e.alpha)
                begin
                    $error("out_alpha: expected %0d, got %0d", e.alpha, m_axis_tdata[31:24]);
                    errors++;
                end
                if (m_axis_tdata[43:32] !== e.row)
                begin
                    $error("out_row: expected %0d, got %0d", e.row, m_axis_tdata[43:32]);
                    errors++;
                end
                if (m_axis_tdata[53:44] !== e.col)
                begin
                    $error("out_column: expected %0d, got %0d", e.col, m_axis_tdata[53:44]);
                    errors++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("last_pixel: expected %0d, got %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    // wait until the block is idle, then let any in-flight work finish
    task automatic drain_block();
        wait (pending_q.size() == 0 && !s_axis_tvalid && filtered_q.size() == 0);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_FRAME_WIDTH:  width_reg  = val[10:0];
            REG_FRAME_HEIGHT: height_reg = val;
            default:          radius_reg = val[1:0];
        endcase
    endtask

    task automatic set_geometry(input logic [12:0] w, input logic [12:0] h,
                                input logic [12:0] r);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_RADIUS, r);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // one whole frame plus its drain; positions past the frame end carry random
    // actions and data, which the block ignores
    task automatic random_frame(input int flush_pct, inout int cnt);
        int unsigned total, span;
        logic [31:0] pix;
        total = eff_w() * eff_h();
        span = total + lag_of();
        for (int unsigned i = 0; i < span; i++)
        begin
            pix = $urandom();
            if ($urandom_range(0, 3) == 0)   // flat regions exercise small deltas
                pix = {pix[31:24], {3{pix[7:0]}}} ^ ($urandom() & 32'h0003_0303);
            if (i < total)
                queue_item(($urandom_range(0, 99) < flush_pct) ? ACT_FLUSH : ACT_PIXEL, pix);
            else
                queue_item(logic'($urandom_range(0, 1)), pix);
            cnt++;
        end
    endtask

    // the start of a frame: a few pixels, each emitted on its own transaction
    task automatic partial_frame(input int n, inout int cnt);
        for (int i = 0; i < n; i++)
        begin
            queue_item(ACT_PIXEL, $urandom());
            cnt++;
        end
    endtask

    initial
    begin
        int cnt;
        int unsigned w, h;
        errors = 0;
        no_gaps = 1'b0;
        gap_left = 0;
        stall_left = 0;
        accepted = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_PIXEL;
        m_axis_tready = 1'b0;
        pos = 0;
        width_reg = 11'd1024;
        height_reg = 13'd1024;
        radius_reg = 2'd2;
        for (int i = 0; i < 19; i++) spatial_w[i] = gauss_q16(i, 18);
        for (int i = 0; i < 256; i++) range_w[i] = gauss_q16(i * i, 1800);
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: 3x3 frame, radius 1, channel extremes, a flush in the frame,
        // two pixels and two flushes in the drain
        set_geometry(3, 3, 1);
        queue_item(ACT_PIXEL, 32'h0000_0000);
        queue_item(ACT_PIXEL, 32'hFFFF_FFFF);
        queue_item(ACT_PIXEL, 32'h00FF_00FF);
        queue_item(ACT_PIXEL, 32'hFF00_FF00);
        queue_item(ACT_PIXEL, 32'h8080_8080);
        queue_item(ACT_FLUSH, 32'hFFFF_FFFF);
        queue_item(ACT_PIXEL, 32'h7F7F_7F7F);
        queue_item(ACT_PIXEL, 32'h0102_0304);
        queue_item(ACT_PIXEL, 32'hFEFD_FCFB);
        queue_item(ACT_PIXEL, 32'hDEAD_BEEF);
        queue_item(ACT_FLUSH, 32'h0);
        queue_item(ACT_FLUSH, 32'h0);
        queue_item(ACT_PIXEL, 32'h1234_5678);
        // hold the sender until this frame has fully drained
        drain_block();

        // oversized width acts as 1024: start of a single row, radius 0
        cnt = 0;
        set_geometry(13'h7FF, 1, 0);
        partial_frame(24, cnt);
        drain_block();

        // oversized height acts as 4096, one column; the position carries on
        set_geometry(1, 13'd5000, 0);
        partial_frame(24, cnt);
        drain_block();

        // 1x1 radius 0: the position restarts at 0, emits on the same transaction
        set_geometry(1, 1, 0);
        queue_item(ACT_PIXEL, 32'hA5C3_0FF0);
        queue_item(ACT_FLUSH, 32'hFFFF_FFFF);
        cnt += 2;
        drain_block();

        // zero width and height act as 1, radius 3 on a 1x1 frame
        set_geometry(0, 0, 3);
        random_frame(10, cnt);
        drain_block();

        // random geometries, mostly small
        while (cnt < 340)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                w = $urandom_range(13, 40);
                h = $urandom_range(1, 2);
            end
            else
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
            end
            set_geometry(13'(w), 13'(h), 13'($urandom_range(0, 3)));
            repeat ((w > 12) ? 1 : $urandom_range(1, 2))
                random_frame($urandom_range(0, 15), cnt);
            drain_block();
        end

        if (filtered_q.size() != 0)
        begin
            $error("%0d expected pixels never came out", filtered_q.size());
            errors++;
        end
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
